// ===== hw/rtl/cda_pkg.sv =====
// Shared constants, types and helper functions for the calendar date arithmetic unit.
package cda_pkg;

    localparam int DATE_W           = 27;
    localparam int DAY_W            = 7;
    localparam int MONTH_W          = 7;
    localparam int YEAR_W           = 14;
    localparam int OP_W             = 2;
    localparam int OFFSET_WIDTH_DEF = 21;
    localparam int OUT_TDATA_W      = ((DATE_W + 7) / 8) * 8;
    localparam int NUM_STAGES       = 15;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_DAYS   = 2'd0,
        OP_ADD_MONTHS = 2'd1,
        OP_VALIDATE   = 2'd2
    } opcode_t;

    // Reciprocal multipliers: x / C == (x * ceil(2^K / C)) >> K for x*C <= 2^K
    localparam int          K_100_27    = 34;
    localparam logic [31:0] R_100_27    = 32'(((64'd1 << K_100_27) + 64'd99) / 64'd100);
    localparam int          K_100_21    = 28;
    localparam logic [31:0] R_100_21    = 32'(((64'd1 << K_100_21) + 64'd99) / 64'd100);
    localparam int          K_100_14    = 21;
    localparam logic [31:0] R_100_14    = 32'(((64'd1 << K_100_14) + 64'd99) / 64'd100);
    localparam int          K_400_14    = 23;
    localparam logic [31:0] R_400_14    = 32'(((64'd1 << K_400_14) + 64'd399) / 64'd400);
    localparam int          K_12_7      = 11;
    localparam logic [31:0] R_12_7      = 32'(((64'd1 << K_12_7) + 64'd11) / 64'd12);
    localparam int          K_12_17     = 21;
    localparam logic [31:0] R_12_17     = 32'(((64'd1 << K_12_17) + 64'd11) / 64'd12);
    localparam int          K_ERA       = 40;
    localparam logic [31:0] R_ERA       = 32'(((64'd1 << K_ERA) + 64'd146096) / 64'd146097);
    localparam int          K_1460      = 29;
    localparam logic [31:0] R_1460      = 32'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
    localparam int          K_36524     = 34;
    localparam logic [31:0] R_36524     = 32'(((64'd1 << K_36524) + 64'd36523) / 64'd36524);
    localparam int          K_146096    = 36;
    localparam logic [31:0] R_146096    = 32'(((64'd1 << K_146096) + 64'd146095) / 64'd146096);
    localparam int          K_365       = 27;
    localparam logic [31:0] R_365       = 32'(((64'd1 << K_365) + 64'd364) / 64'd365);
    localparam int          K_100_9     = 16;
    localparam logic [31:0] R_100_9     = 32'(((64'd1 << K_100_9) + 64'd99) / 64'd100);
    localparam int          K_153       = 19;
    localparam logic [31:0] R_153       = 32'(((64'd1 << K_153) + 64'd152) / 64'd153);

    localparam int DAYS_PER_ERA  = 146097;
    localparam int DAY0_OFFSET   = 146098;   // Yp base plus day field origin
    localparam int ZP_MIN        = 306;      // 0001-01-01 counted from 0000-03-01
    localparam int ZP_MAX        = 3652364;  // 9999-12-31 counted from 0000-03-01
    localparam int TOTAL_MIN     = 12;
    localparam int TOTAL_MAX     = 119999;

    function automatic logic [63:0] rmul(input logic [31:0] x, input logic [31:0] m,
                                         input int k);
        logic [63:0] p;
        p = 64'(x) * 64'(m);
        return p >> k;
    endfunction

    // First day of March-based month mp within its year
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/calendar_date_arithmetic.sv =====
// Top level: pipelined Gregorian date add-days, add-months and validate unit.
// One register stage per step from input request to result.
// Throughput: one request per cycle unless the output stalls; the reciprocal multipliers of the decimal
// split and the day-number-to-date conversion set the stage count.
// Stalls propagate back combinationally through the valid stages, bubbles are squeezed out.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no other state.
module calendar_date_arithmetic
    import cda_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // date_in[26:0], offset, day_in, month_in, year_in, zero pad
    input  logic [((DATE_W + OFFSET_WIDTH + DAY_W + MONTH_W + YEAR_W + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // date_out[26:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // ok
    output logic                   m_tuser
);

    localparam int OW         = OFFSET_WIDTH;
    localparam int POS_OFF    = DATE_W;
    localparam int POS_VD     = POS_OFF + OW;
    localparam int POS_VM     = POS_VD + DAY_W;
    localparam int POS_VY     = POS_VM + MONTH_W;
    localparam int TW         = ((OW > 18) ? OW : 18) + 2;
    localparam int AW         = ((OW > 23) ? OW : 23) + 2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [DATE_W-1:0]        din;
        logic [OW-1:0]            off;
        logic [DAY_W-1:0]         vd;
        logic [MONTH_W-1:0]       vm;
        logic [YEAR_W-1:0]        vy;
        logic [20:0]              q100;
        logic [6:0]               dd;
        logic [6:0]               mm;
        logic [YEAR_W-1:0]        yy;
        logic [7:0]               vq100;
        logic [5:0]               vq400;
        logic                     vok;
        logic [13:0]              yp;
        logic [8:0]               doyb;
        logic [11:0]              yp4;
        logic [7:0]               yp100;
        logic [5:0]               yp400;
        logic [22:0]              dsum;
        logic                     aok;
        logic [21:0]              zp;
        logic [4:0]               era;
        logic [17:0]              doe;
        logic [6:0]               t1;
        logic [2:0]               t2;
        logic                     t3;
        logic [8:0]               yoe;
        logic [8:0]               doy;
        logic [3:0]               mp;
        logic [13:0]              ry0;
        logic [3:0]               rm0;
        logic [4:0]               rd0;
        logic [TW-1:0]            tot;
        logic                     tok;
        logic [16:0]              t17;
        logic [13:0]              q12;
        logic [3:0]               nm1;
        logic [6:0]               c100;
        logic [4:0]               c400;
        logic [4:0]               rd1;
        logic [DATE_W-1:0]        dout;
        logic                     rok;
    } item_t;

    item_t                  pipe_reg  [NUM_STAGES];
    item_t                  pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]  vld_reg;
    logic [NUM_STAGES-1:0]  vld_next;
    logic [NUM_STAGES-1:0]  adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = s_tvalid;
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = OUT_TDATA_W'(pipe_reg[NUM_STAGES-1].dout);
    assign m_tuser  = pipe_reg[NUM_STAGES-1].rok;

    always_comb
    begin
        item_t       it;
        logic [6:0]  m0p;
        logic [3:0]  mq;
        logic [3:0]  nm;
        logic        leap;
        logic [AW-1:0] zs;
        logic [4:0]  maxd;
        logic [17:0] ysum;
        logic [13:0] sy;
        logic [3:0]  sm;
        logic [4:0]  sd;

        // decimal split, first digit pair
        it      = '0;
        it.op   = s_tuser;
        it.din  = s_tdata[DATE_W-1:0];
        it.off  = s_tdata[POS_OFF +: OW];
        it.vd   = s_tdata[POS_VD +: DAY_W];
        it.vm   = s_tdata[POS_VM +: MONTH_W];
        it.vy   = s_tdata[POS_VY +: YEAR_W];
        it.q100 = 21'(rmul(32'(it.din), R_100_27, K_100_27));
        pipe_next[0] = it;

        it    = pipe_reg[0];
        it.dd = 7'(it.din - 27'(it.q100) * 27'd100);
        it.yy = 14'(rmul(32'(it.q100), R_100_21, K_100_21));
        pipe_next[1] = it;

        it       = pipe_reg[1];
        it.mm    = 7'(it.q100 - 21'(it.yy) * 21'd100);
        it.vq100 = 8'(rmul(32'(it.vy), R_100_14, K_100_14));
        it.vq400 = 6'(rmul(32'(it.vy), R_400_14, K_400_14));
        pipe_next[2] = it;

        // month carry, month total, validate
        it    = pipe_reg[2];
        m0p   = it.mm + 7'd11;
        mq    = 4'(rmul(32'(m0p), R_12_7, K_12_7));
        nm    = 4'(m0p - 7'(mq) * 7'd12 + 7'd1);
        it.yp = 14'(it.yy + 14'(mq) + 14'd399 - 14'(nm <= 4'd2));
        it.doyb = cum_days((nm <= 4'd2) ? nm + 4'd9 : nm - 4'd3);
        it.tot  = TW'(it.yy) * TW'(12) + TW'(it.mm) - TW'(1)
                + {{(TW-OW){it.off[OW-1]}}, it.off};
        leap    = (it.vy[1:0] == 2'd0 && it.vy != 14'(it.vq100) * 14'd100)
               || it.vy == 14'(it.vq400) * 14'd400;
        it.vok  = it.vy != '0 && it.vm != '0 && it.vm <= 7'd12 && it.vd != '0
               && it.vd <= 7'(month_days(it.vm[3:0], leap));
        pipe_next[3] = it;

        it       = pipe_reg[3];
        it.yp4   = 12'(it.yp >> 2);
        it.yp100 = 8'(rmul(32'(it.yp), R_100_14, K_100_14));
        it.yp400 = 6'(rmul(32'(it.yp), R_400_14, K_400_14));
        it.tok   = !it.tot[TW-1] && it.tot >= TW'(TOTAL_MIN) && it.tot <= TW'(TOTAL_MAX);
        it.t17   = it.tot[16:0];
        it.q12   = 14'(rmul(32'(it.t17), R_12_17, K_12_17));
        pipe_next[4] = it;

        it      = pipe_reg[4];
        it.dsum = 23'(it.yp) * 23'd365 + 23'(it.yp4) - 23'(it.yp100) + 23'(it.yp400)
                + 23'(it.doyb);
        it.nm1  = 4'(it.t17 - 17'(it.q12) * 17'd12 + 17'd1);
        it.c100 = 7'(rmul(32'(it.q12), R_100_14, K_100_14));
        it.c400 = 5'(rmul(32'(it.q12), R_400_14, K_400_14));
        pipe_next[5] = it;

        // day count from 0000-03-01, month clamp
        it     = pipe_reg[5];
        zs     = AW'(it.dsum) + AW'(it.dd) + {{(AW-OW){it.off[OW-1]}}, it.off}
               - AW'(DAY0_OFFSET);
        it.aok = !zs[AW-1] && zs >= AW'(ZP_MIN) && zs <= AW'(ZP_MAX);
        it.zp  = zs[21:0];
        leap   = (it.q12[1:0] == 2'd0 && it.q12 != 14'(it.c100) * 14'd100)
              || it.q12 == 14'(it.c400) * 14'd400;
        maxd   = month_days(it.nm1, leap);
        it.rd1 = (it.dd > 7'(maxd)) ? maxd : it.dd[4:0];
        pipe_next[6] = it;

        it     = pipe_reg[6];
        it.era = 5'(rmul(32'(it.zp), R_ERA, K_ERA));
        pipe_next[7] = it;

        it     = pipe_reg[7];
        it.doe = 18'(it.zp - 22'(it.era) * 22'(DAYS_PER_ERA));
        pipe_next[8] = it;

        it    = pipe_reg[8];
        it.t1 = 7'(rmul(32'(it.doe), R_1460, K_1460));
        it.t2 = 3'(rmul(32'(it.doe), R_36524, K_36524));
        it.t3 = 1'(rmul(32'(it.doe), R_146096, K_146096));
        pipe_next[9] = it;

        it     = pipe_reg[9];
        ysum   = it.doe - 18'(it.t1) + 18'(it.t2) - 18'(it.t3);
        it.yoe = 9'(rmul(32'(ysum), R_365, K_365));
        pipe_next[10] = it;

        it     = pipe_reg[10];
        it.doy = 9'(it.doe - (18'(it.yoe) * 18'd365 + 18'(it.yoe >> 2)
               - 18'(rmul(32'(it.yoe), R_100_9, K_100_9))));
        pipe_next[11] = it;

        it    = pipe_reg[11];
        it.mp = 4'(rmul(32'(11'(it.doy) * 11'd5 + 11'd2), R_153, K_153));
        pipe_next[12] = it;

        it      = pipe_reg[12];
        it.rd0  = 5'(it.doy - cum_days(it.mp) + 9'd1);
        it.rm0  = (it.mp < 4'd10) ? it.mp + 4'd3 : it.mp - 4'd9;
        it.ry0  = 14'(14'(it.era) * 14'd400 + 14'(it.yoe) + 14'(it.rm0 <= 4'd2));
        pipe_next[13] = it;

        // select and pack
        it = pipe_reg[13];
        sy = it.ry0;
        sm = it.rm0;
        sd = it.rd0;
        case (it.op)
            OP_ADD_DAYS:   it.rok = it.aok;
            OP_ADD_MONTHS:
            begin
                it.rok = it.tok;
                sy     = it.q12;
                sm     = it.nm1;
                sd     = it.rd1;
            end
            OP_VALIDATE:   it.rok = it.vok;
            default:       it.rok = 1'b0;
        endcase
        if (it.rok && it.op != OP_VALIDATE) begin
            it.dout = DATE_W'(sy) * DATE_W'(10000) + DATE_W'(sm) * DATE_W'(100)
                    + DATE_W'(sd);
        end else begin
            it.dout = '0;
        end
        pipe_next[14] = it;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

endmodule

// ===== tb/calendar_date_arithmetic_test.sv =====
// Testbench for the calendar date arithmetic unit: directed and random requests checked in order.
`timescale 1ns / 100ps

class date_scoreboard;
    bit [26:0] date_q[$];
    bit        ok_q[$];
    int        mismatches;
    int        checked;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    function automatic bit is_leap(longint y);
        return ((y - fdiv(y, 4) * 4) == 0 && (y - fdiv(y, 100) * 100) != 0)
            || (y - fdiv(y, 400) * 400) == 0;
    endfunction

    function automatic longint days_in(longint m, longint y);
        longint lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && is_leap(y))
            return 29;
        return lens[m - 1];
    endfunction

    function automatic longint day_number(longint y, longint m, longint d);
        longint era, yoe, mp, doy;
        if (m <= 2)
            y -= 1;
        era = fdiv(y, 400);
        yoe = y - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function automatic void civil(longint z, output longint y, output longint m,
                                  output longint d);
        longint era, doe, yoe, doy, mp;
        z += 719468;
        era = fdiv(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        y   = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2)
            y += 1;
    endfunction

    function automatic void note_request(bit [1:0] op, bit [26:0] date, bit [20:0] offs,
                                         bit [6:0] vd, bit [6:0] vm, bit [13:0] vy);
        longint y, m, d, off, ry, rm, rd, tot, ny, nm, m0;
        bit [26:0] res;
        bit        good;
        y    = date / 10000;
        m    = (date / 100) % 100;
        d    = date % 100;
        off  = longint'($signed(offs));
        res  = '0;
        good = 0;
        case (op)
            cda_pkg::OP_ADD_DAYS:
            begin
                m0 = m - 1;
                ny = y + fdiv(m0, 12);
                nm = m0 - fdiv(m0, 12) * 12 + 1;
                civil(day_number(ny, nm, 1) + d + off - 1, ry, rm, rd);
                if (ry >= 1 && ry <= 9999)
                begin
                    res  = 27'(ry * 10000 + rm * 100 + rd);
                    good = 1;
                end
            end
            cda_pkg::OP_ADD_MONTHS:
            begin
                tot = y * 12 + (m - 1) + off;
                ny  = fdiv(tot, 12);
                nm  = tot - ny * 12 + 1;
                if (d > days_in(nm, ny))
                    d = days_in(nm, ny);
                if (ny >= 1 && ny <= 9999)
                begin
                    res  = 27'(ny * 10000 + nm * 100 + d);
                    good = 1;
                end
            end
            cda_pkg::OP_VALIDATE:
                good = vy >= 1 && vm >= 1 && vm <= 12 && vd >= 1 && vd <= days_in(vm, vy);
            default: ;
        endcase
        date_q.push_back(res);
        ok_q.push_back(good);
    endfunction

    function automatic void check_result(bit [26:0] date, bit ok);
        bit [26:0] ed;
        bit        eo;
        if (date_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result date=%0d ok=%0b", date, ok);
            return;
        end
        ed = date_q.pop_front();
        eo = ok_q.pop_front();
        checked++;
        if (ed != date || eo != ok)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: expected date=%0d ok=%0b, got date=%0d ok=%0b",
                         checked, ed, eo, date, ok);
        end
    endfunction
endclass

module calendar_date_arithmetic_test;
    import cda_pkg::*;

    localparam int IN_W = ((27 + 21 + 7 + 7 + 14 + 7) / 8) * 8;
    localparam int WATCHDOG = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    date_scoreboard sb;
    int send_idle;
    int recv_idle;
    int sent;
    int stall_cycles;
    bit timed_out;
    int op_count[4];

    calendar_date_arithmetic dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[26:0], m_tuser);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (stall_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("calendar_date_arithmetic regression: fail");
            $finish;
        end

    task automatic send_request(bit [1:0] op, bit [26:0] date, bit [20:0] offs,
                                bit [6:0] vd, bit [6:0] vm, bit [13:0] vy);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({vy, vm, vd, offs, date});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, date, offs, vd, vm, vy);
        op_count[op]++;
        sent++;
        @(negedge clk);
    endtask

    task automatic send_random();
        bit [1:0]  op;
        bit [26:0] date;
        bit [20:0] offs;
        int        sel;
        op   = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        sel  = $urandom_range(9);
        if (sel < 7)
            date = 27'($urandom_range(9999, 1) * 10000 + $urandom_range(12, 1) * 100
                       + $urandom_range(31, 1));
        else if (sel < 9)
            date = 27'($urandom_range(99991231));
        else
            date = 27'($urandom);
        sel = $urandom_range(3);
        if (sel == 0)
            offs = 21'($urandom);
        else if (sel == 1)
            offs = 21'($urandom_range(2000) - 1000);
        else
            offs = 21'($urandom_range(60) - 30);
        send_request(op, date, offs, 7'($urandom_range(33)), 7'($urandom_range(14)),
                     ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(2400)));
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        stall_cycles = 0;
        timed_out = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_ADD_DAYS, 27'd20240228, 21'd1, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'd19000228, 21'd1, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'd99991231, 21'd1, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'd00010101, 21'h1FFFFF, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'd20231345, 21'h100000, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'd50000000, 21'h0FFFFF, '0, '0, '0);
        send_request(OP_ADD_DAYS, 27'h7FFFFFF, 21'd0, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd20240131, 21'd1, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd20230131, 21'd1, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd20240500, 21'd3, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd00010101, 21'h1FFFFF, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd99991299, 21'd1, '0, '0, '0);
        send_request(OP_ADD_MONTHS, 27'd00009999, 21'h0FFFFF, '0, '0, '0);
        send_request(OP_VALIDATE, '0, '0, 7'd29, 7'd2, 14'd2000);
        send_request(OP_VALIDATE, '0, '0, 7'd29, 7'd2, 14'd1900);
        send_request(OP_VALIDATE, '0, '0, 7'd31, 7'd4, 14'd2023);
        send_request(OP_VALIDATE, '0, '0, 7'd1, 7'd1, 14'd0);
        send_request(OP_VALIDATE, '0, '0, 7'd0, 7'd13, 14'h3FFF);
        send_request(OP_VALIDATE, '0, '0, 7'h7F, 7'h7F, 14'h3FFF);
        send_request(OP_VALIDATE, '0, '0, 7'd31, 7'd12, 14'h3FFF);
        send_request(2'd3, 27'h7FFFFFF, 21'h1FFFFF, 7'h7F, 7'h7F, 14'h3FFF);

        send_idle = 12;
        recv_idle = 47;
        repeat (170) send_random();
        send_idle = 47;
        recv_idle = 12;
        repeat (170) send_random();
        send_idle = 0;
        recv_idle = 0;
        repeat (170) send_random();
        s_tvalid <= 1'b0;

        while (sb.date_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("%0d requests (add days %0d, add months %0d, validate %0d, unused %0d)",
                 sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("calendar_date_arithmetic regression: pass");
        else
            $display("calendar_date_arithmetic regression: fail");
        $finish;
    end
endmodule
